@@ rtl/dscp_from_number_list_parser_defines.svh @@
// assertion macros for the dscp parser checker
`ifndef DSCP_FROM_NUMBER_LIST_PARSER_DEFINES_SVH
`define DSCP_FROM_NUMBER_LIST_PARSER_DEFINES_SVH

// consequent must hold in the same cycle
`define DFNL_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the following cycle
`define DFNL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dfnl_pkg.sv @@
package dfnl_pkg;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
	localparam int unsigned CNT_W = 11;
	localparam logic [CNT_W-1:0] COUNT_MAX = 11'd2047;

	// one completed number and/or end of string
	typedef struct packed {
		logic       has_num;
		logic       le63;
		logic       key_eq;
		logic [5:0] low;
		logic       is_end;
	} qword_t;

endpackage

@@ rtl/dfnl_front.sv @@
module dfnl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        ch,
	input  logic              last,
	input  logic [7:0]        lookup_qos,
	output logic              push,
	output dfnl_pkg::qword_t  word
);
	import dfnl_pkg::*;

	logic [31:0] acc_q;
	logic        in_num_q;
	logic        digit;
	logic [31:0] acc_next;
	logic [31:0] value;

	always_comb begin
		digit = ch inside {[CH_ZERO:CH_NINE]};
		acc_next = (acc_q << 3) + (acc_q << 1) + {28'd0, ch[3:0]};
		value = digit ? acc_next : acc_q;
		push = accept && (last || (!digit && in_num_q));
		word.has_num = digit || in_num_q;
		word.le63 = (value[31:6] == 26'd0);
		word.key_eq = (value == {24'd0, lookup_qos});
		word.low = value[5:0];
		word.is_end = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			in_num_q <= 1'b0;
		end else if (accept) begin
			if (last || !digit) begin
				acc_q <= '0;
				in_num_q <= 1'b0;
			end else begin
				acc_q <= acc_next;
				in_num_q <= 1'b1;
			end
		end
	end

endmodule

@@ rtl/dfnl_fifo.sv @@
module dfnl_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  dfnl_pkg::qword_t  wr_word,
	input  logic              pop,
	output dfnl_pkg::qword_t  rd_word,
	output logic              empty,
	output logic              full
);
	import dfnl_pkg::*;

	qword_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign empty = (cnt_q == '0);
	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_word = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/dfnl_back.sv @@
module dfnl_back (
	input  logic              clk,
	input  logic              arst_n,
	input  dfnl_pkg::qword_t  word,
	input  logic              empty,
	input  logic [7:0]        lookup_qos,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              found,
	output logic [5:0]        dscp
);
	import dfnl_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             key_match_q;
	logic             index_hit_q;
	logic [5:0]       index_value_q;
	logic             pair_hit_q;
	logic [5:0]       pair_value_q;
	logic             out_valid_q;
	logic             found_q;
	logic [5:0]       dscp_q;

	logic             take;
	logic             idx_set;
	logic             pair_set;
	logic             index_hit_n;
	logic [5:0]       index_value_n;
	logic             pair_hit_n;
	logic [5:0]       pair_value_n;

	assign out_valid = out_valid_q;
	assign found = found_q;
	assign dscp = dscp_q;

	always_comb begin
		pop = !empty && (!word.is_end || !out_valid_q || !out_stall);
		take = word.has_num && (count_q != COUNT_MAX);
		idx_set = take && (count_q == {3'd0, lookup_qos}) && word.le63;
		pair_set = take && count_q[0] && key_match_q && word.le63 && !pair_hit_q;
		index_hit_n = index_hit_q || idx_set;
		index_value_n = idx_set ? word.low : index_value_q;
		pair_hit_n = pair_hit_q || pair_set;
		pair_value_n = pair_set ? word.low : pair_value_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			key_match_q <= 1'b0;
			index_hit_q <= 1'b0;
			index_value_q <= '0;
			pair_hit_q <= 1'b0;
			pair_value_q <= '0;
			out_valid_q <= 1'b0;
			found_q <= 1'b0;
			dscp_q <= '0;
		end else begin
			if (pop && word.is_end) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (word.is_end) begin
					count_q <= '0;
					key_match_q <= 1'b0;
					index_hit_q <= 1'b0;
					index_value_q <= '0;
					pair_hit_q <= 1'b0;
					pair_value_q <= '0;
					found_q <= index_hit_n || pair_hit_n;
					dscp_q <= index_hit_n ? index_value_n :
						(pair_hit_n ? pair_value_n : 6'd0);
				end else begin
					if (take) begin
						count_q <= count_q + 1'b1;
						if (!count_q[0]) begin
							key_match_q <= word.key_eq;
						end
					end
					index_hit_q <= index_hit_n;
					index_value_q <= index_value_n;
					pair_hit_q <= pair_hit_n;
					pair_value_q <= pair_value_n;
				end
			end
		end
	end

endmodule

@@ rtl/dscp_from_number_list_parser.sv @@
// dscp lookup from a streamed number list
// throughput: one character word per cycle while the result side keeps up
// result path: the last character's word is written into the queue, then popped into the result register
// a four-entry queue between front and back absorbs result-side stalls
// reset clears the parse state, the queue, the result register and lookup_qos to 0
module dscp_from_number_list_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] ch,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       found,
	output logic [5:0] dscp,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);
	import dfnl_pkg::*;

	logic [7:0] lookup_qos_q;
	logic       accept;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;
	qword_t     push_word;
	qword_t     pop_word;

	assign cfg_ready = 1'b1;
	assign in_stall = full;
	assign accept = in_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_qos_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			lookup_qos_q <= cfg_data;
		end
	end

	dfnl_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.ch         (ch),
		.last       (last),
		.lookup_qos (lookup_qos_q),
		.push       (push),
		.word       (push_word)
	);

	dfnl_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_word (push_word),
		.pop     (pop),
		.rd_word (pop_word),
		.empty   (empty),
		.full    (full)
	);

	dfnl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.word       (pop_word),
		.empty      (empty),
		.lookup_qos (lookup_qos_q),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.found      (found),
		.dscp       (dscp)
	);

endmodule

@@ rtl/dfnl_checker.sv @@
`include "dscp_from_number_list_parser_defines.svh"

module dfnl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] ch,
	input logic       last,
	input logic       out_valid,
	input logic       out_stall,
	input logic       found,
	input logic [5:0] dscp,
	input logic       cfg_valid,
	input logic       cfg_ready
);

	`DFNL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({found, dscp}), "result moved")
	`DFNL_ASSERT_SAME(a_miss_zero, out_valid && !found, dscp == 6'd0, "dscp nonzero on a miss")
	`DFNL_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready, "config write refused")
	`DFNL_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable({ch, last}), "input word moved")
	`DFNL_ASSERT_SAME(a_in_stall, in_stall, out_valid, "input stalled with no result waiting")

endmodule

bind dscp_from_number_list_parser dfnl_checker u_dfnl_checker (.*);

@@ sim/tb_top.sv @@
module tb_top;
	import dfnl_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_CHARS = 80;
	localparam logic [31:0] DSCP_TOP = 32'd63;
	localparam logic [31:0] RADIX = 32'd10;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		logic       hit;
		logic [5:0] code;
	} dscp_result_t;

	typedef struct packed {
		logic [7:0] chr;
		logic       eos;
		logic       pinned;
		logic       p_hit;
		logic [5:0] p_code;
	} char_row_t;

	localparam int N_DIRECTED = 22;
	localparam char_row_t DIRECTED [N_DIRECTED] = '{
		'{"9", 1'b1, 1'b1, 1'b1, 6'd9},
		'{"x", 1'b1, 1'b1, 1'b0, 6'd0},
		'{"6", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"3", 1'b0, 1'b0, 1'b0, 6'd0},
		'{",", 1'b1, 1'b1, 1'b1, 6'd63},
		'{"6", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"4", 1'b0, 1'b0, 1'b0, 6'd0},
		'{",", 1'b1, 1'b1, 1'b0, 6'd0},
		'{8'hff, 1'b0, 1'b0, 1'b0, 6'd0},
		'{8'h00, 1'b0, 1'b0, 1'b0, 6'd0},
		'{8'h2f, 1'b0, 1'b0, 1'b0, 6'd0},
		'{8'h3a, 1'b1, 1'b1, 1'b0, 6'd0},
		'{"4", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"2", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"9", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"4", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"9", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"6", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"7", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"3", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"0", 1'b0, 1'b0, 1'b0, 6'd0},
		'{"6", 1'b1, 1'b0, 1'b0, 6'd0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] ch = 8'd0;
	logic       last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       found;
	logic [5:0] dscp;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'd0;

	dscp_from_number_list_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.dscp      (dscp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// parser shadow state
	logic [7:0]  p_qos = 8'd0;
	logic [31:0] p_acc;
	logic        p_open;
	logic [10:0] p_count;
	logic        p_key_match;
	logic        p_idx_hit;
	logic [5:0]  p_idx_val;
	logic        p_pair_hit;
	logic [5:0]  p_pair_val;

	dscp_result_t lookup_q[$];
	logic [7:0]   str_q[$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned hold_req = 0;
	int unsigned hold_ack = 0;
	int unsigned hold_left = 0;
	int unsigned chars_sent = 0;
	int unsigned strings_sent = 0;
	int unsigned results_seen = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;

	function automatic void clear_parse();
		p_acc = '0;
		p_open = 1'b0;
		p_count = '0;
		p_key_match = 1'b0;
		p_idx_hit = 1'b0;
		p_idx_val = '0;
		p_pair_hit = 1'b0;
		p_pair_val = '0;
	endfunction

	function automatic void close_number();
		logic [31:0] v;
		logic [10:0] k;
		v = p_acc;
		k = p_count;
		p_acc = '0;
		p_open = 1'b0;
		if (k >= COUNT_MAX)
			return;
		if (k == p_qos && v <= DSCP_TOP) begin
			p_idx_hit = 1'b1;
			p_idx_val = v[5:0];
		end
		if (!k[0])
			p_key_match = (v == p_qos);
		else if (p_key_match && v <= DSCP_TOP && !p_pair_hit) begin
			p_pair_hit = 1'b1;
			p_pair_val = v[5:0];
		end
		p_count = k + 11'd1;
	endfunction

	function automatic dscp_result_t parse_char(input logic [7:0] c, input logic eos);
		dscp_result_t res;
		res = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			p_acc = p_acc * RADIX + 32'(c - CH_ZERO);
			p_open = 1'b1;
		end else if (p_open)
			close_number();
		if (eos) begin
			if (p_open)
				close_number();
			if (p_idx_hit)
				res = '{hit: 1'b1, code: p_idx_val};
			else if (p_pair_hit)
				res = '{hit: 1'b1, code: p_pair_val};
			clear_parse();
		end
		return res;
	endfunction

	// one character word per call, prediction taken at the accepting edge
	task automatic send_word(input logic [7:0] c, input logic eos, input logic pin,
			input dscp_result_t pinned_res);
		dscp_result_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		last <= eos;
		do @(posedge clk); while (in_stall);
		chars_sent++;
		res = parse_char(c, eos);
		if (eos)
			lookup_q.insert(lookup_q.size(), pin ? pinned_res : res);
	endtask

	task automatic send_string();
		for (int i = 0; i < str_q.size(); i++)
			send_word(str_q[i], i == str_q.size() - 1, 1'b0, '0);
		strings_sent++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (lookup_q.size() != 0);
	endtask

	task automatic write_qos(input logic [7:0] v);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		p_qos = v;
	endtask

	function automatic void add_number(input logic [31:0] v);
		logic [7:0]  digs[$];
		logic [31:0] x;
		x = v;
		do begin
			digs.push_front(CH_ZERO + 8'(x % RADIX));
			x = x / RADIX;
		end while (x != 0);
		if ($urandom_range(99) < 8)
			digs.push_front(CH_ZERO);
		foreach (digs[i])
			str_q.insert(str_q.size(), digs[i]);
	endfunction

	function automatic void add_sep();
		int unsigned r;
		logic [7:0]  b;
		r = $urandom_range(99);
		if (r < 50)
			b = ",";
		else if (r < 65)
			b = " ";
		else if (r < 75)
			b = ":";
		else begin
			b = 8'($urandom_range(0, 245));
			if (b >= CH_ZERO)
				b += 8'd10;
		end
		str_q.insert(str_q.size(), b);
		if ($urandom_range(99) < 10)
			str_q.insert(str_q.size(), ",");
	endfunction

	function automatic logic [31:0] pick_value(input int unsigned i, input int unsigned n);
		int unsigned r;
		if (n > COUNT_MAX) begin
			// only a pair past the count limit could match, unless p_qos is below 10
			if (i == p_qos)
				return 32'd99;
			if (i >= COUNT_MAX - 3)
				return i[0] ? ((i == COUNT_MAX) ? 32'd5 : 32'd99) : 32'(p_qos);
			return $urandom_range(0, 9);
		end
		if (n > 100)
			return $urandom_range(0, 9);
		r = $urandom_range(99);
		if (r < 30)
			return 32'(p_qos);
		if (r < 60)
			return $urandom_range(0, 63);
		if (r < 75)
			return $urandom_range(64, 999);
		if (r < 85)
			return $urandom();
		if (r < 90)
			return 32'd63 + $urandom_range(0, 1);
		return $urandom_range(0, 9);
	endfunction

	function automatic void build_list(input int unsigned n);
		bit long_list;
		long_list = n > 100;
		str_q.delete();
		if (!long_list && $urandom_range(99) < 20)
			add_sep();
		for (int unsigned i = 0; i < n; i++) begin
			// numbers past 32 bits wrap
			if (!long_list && $urandom_range(99) < 6)
				repeat ($urandom_range(11, 14))
					str_q.insert(str_q.size(), CH_ZERO + 8'($urandom_range(0, 9)));
			else
				add_number(pick_value(i, n));
			if (i + 1 < n) begin
				if (long_list)
					str_q.insert(str_q.size(), ",");
				else
					add_sep();
			end
		end
		if (str_q.size() == 0 || (!long_list && $urandom_range(99) < 50))
			add_sep();
	endfunction

	function automatic void build_noise();
		str_q.delete();
		repeat ($urandom_range(1, 16))
			str_q.insert(str_q.size(),
				($urandom_range(99) < 50) ? CH_ZERO + 8'($urandom_range(0, 9)) :
				8'($urandom_range(0, 255)));
	endfunction

	task automatic run_phase(input logic [7:0] qos, input idle_mode_t mode, input bit squeeze);
		int unsigned start;
		int unsigned n;
		bit paused;
		write_qos(qos);
		case (mode)
			IDLE_NONE: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
			IDLE_SENDER: begin
				tx_idle_pct = 48;
				rx_stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				tx_idle_pct = 0;
				rx_stall_pct = 48;
			end
			IDLE_BOTH: begin
				tx_idle_pct = 26;
				rx_stall_pct = 26;
			end
			default: begin
				tx_idle_pct = 0;
				rx_stall_pct = 0;
			end
		endcase
		if (squeeze)
			hold_req++;
		start = chars_sent;
		paused = 1'b0;
		while (chars_sent - start < PHASE_CHARS) begin
			if ($urandom_range(99) < 15)
				build_noise();
			else begin
				if ($urandom_range(99) < 30 && p_qos <= 24)
					n = p_qos + $urandom_range(0, 2);
				else
					n = $urandom_range(0, 6);
				build_list(n);
			end
			send_string();
			if (squeeze && !paused && chars_sent - start >= PHASE_CHARS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	// result side: random stall plus a long hold on request
	always @(posedge clk) begin
		if (hold_left != 0)
			hold_left--;
		else if (hold_req != hold_ack) begin
			hold_left = HOLD_CYCLES;
			hold_ack = hold_req;
		end
		out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin : check_results
		dscp_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (lookup_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result word: found=%0d dscp=%0d", found, dscp);
			end else begin
				want = lookup_q.pop_front();
				if (found !== want.hit || dscp !== want.code) begin
					errors++;
					if (errors <= 10)
						$display("result %0d: expected found=%0d dscp=%0d, got found=%0d dscp=%0d",
							results_seen, want.hit, want.code, found, dscp);
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count, lookup_q.size());
		$display("FAILURE");
		$finish;
	end

	initial begin
		clear_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < N_DIRECTED; i++)
			send_word(DIRECTED[i].chr, DIRECTED[i].eos, DIRECTED[i].pinned,
				'{hit: DIRECTED[i].p_hit, code: DIRECTED[i].p_code});
		run_phase(8'd3, IDLE_NONE, 1'b0);
		run_phase(8'd0, IDLE_SENDER, 1'b0);
		run_phase(8'd255, IDLE_RECEIVER, 1'b0);
		build_list(256);
		send_string();
		run_phase(8'd1, IDLE_BOTH, 1'b0);
		run_phase(8'($urandom_range(2, 12)), IDLE_NONE, 1'b1);
		run_phase(8'($urandom_range(0, 255)), IDLE_SENDER, 1'b0);
		run_phase(8'd2, IDLE_RECEIVER, 1'b0);
		run_phase(8'($urandom_range(0, 20)), IDLE_BOTH, 1'b0);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d characters in %0d strings, %0d lookup results checked, %0d errors",
			chars_sent, strings_sent, results_seen, errors);
		$display("lookup_qos from 0 to 255, wrapped numbers, index 255, idle/stall mixes, long hold");
		if (errors == 0 && lookup_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/dfnl_pkg.sv
rtl/dfnl_front.sv
rtl/dfnl_fifo.sv
rtl/dfnl_back.sv
rtl/dscp_from_number_list_parser.sv
rtl/dfnl_checker.sv
sim/tb_top.sv
